/* rtl/pefl_pkg.sv */
// ----------------------------------------------------------------------------
// pefl_pkg
// Shared types, codes and sizes for the page extent free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pefl_pkg;

	// Sizes of the extent stack and of page frame numbers.
	localparam int MAX_EXTENTS = 64;
	localparam int PFN_BITS    = 40;
	localparam int FIELD_W     = 40;
	localparam int DEPTH_W     = $clog2(MAX_EXTENTS + 1);
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int ENTRY_W     = PFN_BITS + FIELD_W;

	// Operation codes of a request.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	// Status codes of a response.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	// Command kinds decided by the front end.
	localparam logic [1:0] K_PUSH  = 2'd0;
	localparam logic [1:0] K_ALLOC = 2'd1;
	localparam logic [1:0] K_ZERO  = 2'd2;
	localparam logic [1:0] K_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [FIELD_W-1:0] page;
		logic [FIELD_W-1:0] npages;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] alloc_page;
		logic               now_empty;
	} out_t;

	// Classified command passed from the front end to the back end.
	typedef struct packed {
		logic [1:0]          kind;
		logic [PFN_BITS-1:0] base;
		logic [FIELD_W-1:0]  pages;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/pefl_ram.sv */
// ----------------------------------------------------------------------------
// pefl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pefl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/pefl_front.sv */
// ----------------------------------------------------------------------------
// pefl_front
// Request stage: takes a request transfer and classifies it into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module pefl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pefl_pkg::in_t req,
	output logic               busy,
	output logic               cmd_valid,
	output pefl_pkg::cmd_t     cmd,
	input  wire logic          cmd_taken
);

	logic           valid_s1;
	pefl_pkg::cmd_t cmd_s1;
	pefl_pkg::cmd_t cmd_d;
	logic           accept;

	// The stage is blocked only while its held command cannot move on.
	assign busy   = valid_s1 && !cmd_taken;
	assign accept = start && !busy;

	// Decode the operation into a stack command.
	always_comb begin
		cmd_d.base  = pefl_pkg::PFN_BITS'(req.page);
		cmd_d.pages = req.npages;
		unique case (req.op)
			pefl_pkg::OP_ADD: begin
				cmd_d.kind = (req.npages == '0) ? pefl_pkg::K_ZERO : pefl_pkg::K_PUSH;
			end
			pefl_pkg::OP_ALLOC: begin
				cmd_d.kind = pefl_pkg::K_ALLOC;
			end
			pefl_pkg::OP_FREE: begin
				cmd_d.kind  = pefl_pkg::K_PUSH;
				cmd_d.pages = pefl_pkg::FIELD_W'(1);
			end
			default: begin
				cmd_d.kind = pefl_pkg::K_NOP;
			end
		endcase
	end

	// Holding register for the classified command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_taken) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

/* rtl/pefl_queue.sv */
// ----------------------------------------------------------------------------
// pefl_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pefl_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	input  wire pefl_pkg::cmd_t wr_cmd,
	output logic                wr_ready,
	output logic                rd_valid,
	output pefl_pkg::cmd_t      rd_cmd,
	input  wire logic           rd_pop
);

	pefl_pkg::cmd_t slot_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_cmd   = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

/* rtl/pefl_back.sv */
// ----------------------------------------------------------------------------
// pefl_back
// Extent stack: top extent cached in registers, the rest in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module pefl_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire pefl_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                done,
	output pefl_pkg::out_t      rsp
);

	localparam logic S_RUN    = 1'b0;
	localparam logic S_REFILL = 1'b1;

	logic                            state_q;
	logic                            state_d;
	logic [pefl_pkg::DEPTH_W-1:0]    depth_q;
	logic [pefl_pkg::DEPTH_W-1:0]    depth_d;
	logic [pefl_pkg::PFN_BITS-1:0]   top_base_q;
	logic [pefl_pkg::FIELD_W-1:0]    top_pages_q;
	logic                            done_q;
	pefl_pkg::out_t                  rsp_q;
	pefl_pkg::out_t                  rsp_d;
	logic                            load_top;
	logic                            step_top;
	logic                            ram_we;
	logic [pefl_pkg::IDX_W-1:0]      waddr;
	logic [pefl_pkg::IDX_W-1:0]      raddr;
	logic [pefl_pkg::ENTRY_W-1:0]    rdata;
	logic                            full;
	logic                            empty;

	assign full    = (depth_q == pefl_pkg::DEPTH_W'(pefl_pkg::MAX_EXTENTS));
	assign empty   = (depth_q == '0);
	assign cmd_pop = cmd_valid && (state_q == S_RUN);

	// The current top is spilled at its own index; the new top after a pop
	// sits one below the current top.
	assign waddr = pefl_pkg::IDX_W'(depth_q - pefl_pkg::DEPTH_W'(1));
	assign raddr = pefl_pkg::IDX_W'(depth_q - pefl_pkg::DEPTH_W'(2));

	pefl_ram #(
		.WIDTH (pefl_pkg::ENTRY_W),
		.DEPTH (pefl_pkg::MAX_EXTENTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata ({top_base_q, top_pages_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Command execution against the cached top extent.
	always_comb begin
		state_d       = state_q;
		depth_d       = depth_q;
		load_top      = 1'b0;
		step_top      = 1'b0;
		ram_we        = 1'b0;
		rsp_d.status  = pefl_pkg::ST_OK;
		rsp_d.alloc_page = '0;
		unique case (state_q)
			S_RUN: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						pefl_pkg::K_PUSH: begin
							if (full) begin
								rsp_d.status = pefl_pkg::ST_FULL;
							end else begin
								ram_we   = !empty;
								load_top = 1'b1;
								depth_d  = depth_q + pefl_pkg::DEPTH_W'(1);
							end
						end
						pefl_pkg::K_ALLOC: begin
							if (empty) begin
								rsp_d.status = pefl_pkg::ST_EMPTY;
							end else begin
								rsp_d.alloc_page = pefl_pkg::FIELD_W'(top_base_q);
								if (top_pages_q <= pefl_pkg::FIELD_W'(1)) begin
									depth_d = depth_q - pefl_pkg::DEPTH_W'(1);
									if (depth_q > pefl_pkg::DEPTH_W'(1)) begin
										state_d = S_REFILL;
									end
								end else begin
									step_top = 1'b1;
								end
							end
						end
						pefl_pkg::K_ZERO: begin
							rsp_d.status = pefl_pkg::ST_ZERO;
						end
						default: begin
							rsp_d.status = pefl_pkg::ST_OK;
						end
					endcase
				end
			end
			S_REFILL: begin
				state_d = S_RUN;
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
		rsp_d.now_empty = (depth_d == '0);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			depth_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			done_q  <= cmd_pop;
		end
	end

	// Top extent cache and response register.
	always_ff @(posedge clk) begin
		if (load_top) begin
			top_base_q  <= cmd.base;
			top_pages_q <= cmd.pages;
		end else if (step_top) begin
			top_base_q  <= top_base_q + pefl_pkg::PFN_BITS'(1);
			top_pages_q <= top_pages_q - pefl_pkg::FIELD_W'(1);
		end else if (state_q == S_REFILL) begin
			{top_base_q, top_pages_q} <= rdata;
		end
		if (cmd_pop) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

/* rtl/page_extent_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// page_extent_free_list_allocator
// LIFO free list of page extents with add, allocate and free requests.
// ----------------------------------------------------------------------------
// A request transfer is taken on a clock edge with start high and busy low.
// Each request yields one response, shown on rsp for a single cycle while done
// is high; the receiver cannot stall it. A request passes through the request
// stage and the command queue; its response is held in the response register.
// Up to one request is taken per cycle while busy is low. An allocate that uses
// up the top extent while others are stored below it sends the back end through
// its refill state, for the registered read of the extent RAM that refills the
// cached top; a two-entry queue between the request stage and the back end
// absorbs it, and busy rises only when both are full. The extent RAM needs no
// clearing after reset.
`default_nettype none

module page_extent_free_list_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pefl_pkg::in_t req,
	output logic               done,
	output pefl_pkg::out_t     rsp
);

	logic           front_valid;
	pefl_pkg::cmd_t front_cmd;
	logic           queue_ready;
	logic           queue_valid;
	pefl_pkg::cmd_t queue_cmd;
	logic           queue_pop;

	pefl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cmd_valid (front_valid),
		.cmd       (front_cmd),
		.cmd_taken (queue_ready)
	);

	pefl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_cmd   (front_cmd),
		.wr_ready (queue_ready),
		.rd_valid (queue_valid),
		.rd_cmd   (queue_cmd),
		.rd_pop   (queue_pop)
	);

	pefl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_pop),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page extent free-list allocator. A short table
// of directed requests covers empty, full, zero-count and wrap cases; random
// phases then push and pop the extent stack between empty and full. Responses
// are checked field by field against the in-bench stack model or a typed-in row.
// ----------------------------------------------------------------------------
module tb_top;
	import pefl_pkg::*;

	localparam int RAND_ITEMS   = 1550;
	localparam int QUIET_TAIL   = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int REPORT_MAX   = 10;

	localparam logic [FIELD_W-1:0] PFN_MAX   = '1;
	localparam logic [FIELD_W-1:0] PFN_PAGE  = 40'h1000;
	localparam logic [FIELD_W-1:0] PFN_MIXED = 40'h5a5a5a5a5a;
	localparam logic [1:0]         OP_UNUSED = 2'd3;

	// One line of the directed table: a request, how often to send it, and
	// optionally the response typed in by hand.
	typedef struct packed {
		in_t        item;
		logic [7:0] reps;
		logic       known;
		out_t       want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  req;
	logic done;
	out_t rsp;

	page_extent_free_list_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Model of the extent stack.
	logic [PFN_BITS-1:0] ext_base  [MAX_EXTENTS];
	logic [FIELD_W-1:0]  ext_pages [MAX_EXTENTS];
	int unsigned         ext_depth = 0;

	// Responses still owed by the allocator, oldest first.
	out_t pending_rsp [$];

	int unsigned xfers_taken  = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned n_full       = 0;
	int unsigned n_empty      = 0;
	int unsigned n_zero       = 0;
	int unsigned n_directed   = 0;
	logic        cur_known;
	out_t        cur_want;
	out_t        step_rsp;
	out_t        oldest_rsp;

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Pushes one extent unless the stack is full.
	function automatic logic [1:0] stack_push(input logic [PFN_BITS-1:0] base,
			input logic [FIELD_W-1:0] pages);
		if (ext_depth >= MAX_EXTENTS)
			return ST_FULL;
		ext_base[ext_depth]  = base;
		ext_pages[ext_depth] = pages;
		ext_depth++;
		return ST_OK;
	endfunction

	// Applies one request to the stack model and returns its response.
	function automatic out_t free_list_step(input in_t r);
		out_t o;
		int unsigned t;
		o = '0;
		o.status = ST_OK;
		case (r.op)
			OP_ADD: begin
				// A zero-count region is rejected before the full check.
				if (r.npages == '0)
					o.status = ST_ZERO;
				else
					o.status = stack_push(r.page[PFN_BITS-1:0], r.npages);
			end
			OP_ALLOC: begin
				if (ext_depth == 0) begin
					o.status = ST_EMPTY;
				end else begin
					t = ext_depth - 1;
					o.alloc_page = ext_base[t];
					// The last page pops the extent; otherwise the base advances
					// with wrap-around and the count shrinks.
					if (ext_pages[t] <= 1) begin
						ext_depth = t;
					end else begin
						ext_base[t]  = ext_base[t] + 1'b1;
						ext_pages[t] = ext_pages[t] - 1'b1;
					end
				end
			end
			OP_FREE: begin
				o.status = stack_push(r.page[PFN_BITS-1:0], 40'd1);
			end
			default: begin
			end
		endcase
		o.now_empty = (ext_depth == 0);
		return o;
	endfunction

	function automatic logic [FIELD_W-1:0] random_pfn();
		logic [FIELD_W-1:0] v;
		v[FIELD_W-1:32] = 8'($urandom_range(0, 255));
		v[31:0]         = $urandom();
		return v;
	endfunction

	function automatic plan_row_t plan_row(input logic [1:0] op,
			input logic [FIELD_W-1:0] page, input logic [FIELD_W-1:0] count,
			input int reps, input int known, input logic [1:0] status,
			input logic [FIELD_W-1:0] apage, input int empty);
		plan_row_t p;
		p.item.op         = op;
		p.item.page       = page;
		p.item.npages     = count;
		p.reps            = 8'(reps);
		p.known           = (known != 0);
		p.want.status     = status;
		p.want.alloc_page = apage;
		p.want.now_empty  = (empty != 0);
		return p;
	endfunction

	task automatic log_fault(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// Offers one request and waits for its transfer.
	task automatic issue(input in_t item, input logic known, input out_t want);
		int unsigned mark;
		mark      = xfers_taken;
		cur_known = known;
		cur_want  = want;
		start <= 1'b1;
		req   <= item;
		do
			@(negedge clk);
		while (xfers_taken == mark);
	endtask

	task automatic sender_gap(input logic allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// Request side: every transfer updates the model and queues the response.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			step_rsp = free_list_step(req);
			pending_rsp.push_back(cur_known ? cur_want : step_rsp);
			xfers_taken++;
		end
	end

	// Response side: each strobed response is matched against the oldest one.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			case (rsp.status)
				ST_FULL:  n_full++;
				ST_EMPTY: n_empty++;
				ST_ZERO:  n_zero++;
				default: begin
				end
			endcase
			if (pending_rsp.size() == 0) begin
				log_fault($sformatf("Unexpected response: status %0d page %h empty %b",
					rsp.status, rsp.alloc_page, rsp.now_empty));
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				if (rsp.status !== oldest_rsp.status ||
						rsp.alloc_page !== oldest_rsp.alloc_page ||
						rsp.now_empty !== oldest_rsp.now_empty)
					log_fault($sformatf({"Response %0d: expected status %0d page %h ",
						"empty %b, got status %0d page %h empty %b"}, results_seen,
						oldest_rsp.status, oldest_rsp.alloc_page, oldest_rsp.now_empty,
						rsp.status, rsp.alloc_page, rsp.now_empty));
			end
		end
	end

	// Main sequence.
	initial begin
		plan_row_t   plan [$];
		in_t         item;
		int unsigned push_bias;
		int unsigned pick;
		logic        idle_on;
		logic        late;

		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cur_known = 1'b0;
		cur_want  = '0;

		// Directed table. Rows with known set carry a hand-written response.
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_EMPTY, '0,      1));
		plan.push_back(plan_row(OP_UNUSED, PFN_MAX,   PFN_MAX,  1, 1, ST_OK,    '0,      1));
		plan.push_back(plan_row(OP_ADD,    PFN_MAX,   '0,       1, 1, ST_ZERO,  '0,      1));
		plan.push_back(plan_row(OP_ADD,    PFN_MAX,   40'd2,    1, 1, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    PFN_MAX, 0));
		// The base has wrapped to zero and the last page pops the extent.
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    '0,      1));
		plan.push_back(plan_row(OP_FREE,   PFN_MIXED, PFN_MAX,  1, 1, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ADD,    '0,        40'd3,    1, 1, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    40'd1,   0));
		plan.push_back(plan_row(OP_ALLOC,  PFN_MAX,   PFN_MAX,  1, 1, ST_OK,    40'd2,   0));
		plan.push_back(plan_row(OP_FREE,   PFN_MAX,   '0,       1, 0, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    PFN_MAX, 0));
		// Fill the stack to the brim with single pages.
		plan.push_back(plan_row(OP_FREE,   PFN_PAGE,  '0,      63, 0, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ADD,    40'd1,     '0,       1, 1, ST_ZERO,  '0,      0));
		plan.push_back(plan_row(OP_ADD,    40'd1,     PFN_MAX,  1, 1, ST_FULL,  '0,      0));
		plan.push_back(plan_row(OP_FREE,   40'd1,     '0,       1, 1, ST_FULL,  '0,      0));
		plan.push_back(plan_row(OP_UNUSED, '0,        '0,       1, 1, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_OK,    PFN_PAGE, 0));
		plan.push_back(plan_row(OP_FREE,   PFN_MAX,   '0,       1, 1, ST_OK,    '0,      0));
		// Drain everything again.
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,      64, 0, ST_OK,    '0,      0));
		plan.push_back(plan_row(OP_ALLOC,  '0,        '0,       1, 1, ST_EMPTY, '0,      1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			repeat (plan[k].reps) begin
				sender_gap(1'b1);
				issue(plan[k].item, plan[k].known, plan[k].want);
				n_directed++;
			end
		end

		// Random phases: the push bias changes every 64 requests so the stack
		// swings between empty and full. Huge counts come only near the end,
		// since such an extent would never drain.
		push_bias = 50;
		idle_on   = 1'b1;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			late = (i >= RAND_ITEMS - QUIET_TAIL);
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: push_bias = 25;
					1: push_bias = 50;
					default: push_bias = 85;
				endcase
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if (late)
				idle_on = 1'b0;

			item.npages = random_pfn();
			pick = $urandom_range(0, 99);
			if (pick < 10)
				item.page = PFN_MAX - 40'($urandom_range(0, 3));
			else if (pick < 20)
				item.page = 40'($urandom_range(0, 15));
			else
				item.page = random_pfn();

			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				item.op = OP_UNUSED;
			end else if (pick < 5) begin
				item.op     = OP_ADD;
				item.npages = '0;
			end else if (pick < push_bias) begin
				if ($urandom_range(0, 1) == 0) begin
					item.op = OP_FREE;
				end else begin
					item.op = OP_ADD;
					pick = $urandom_range(0, 99);
					if (pick < 70)
						item.npages = 40'($urandom_range(1, 3));
					else if (pick < 90)
						item.npages = 40'($urandom_range(4, 40));
					else if (pick < 97)
						item.npages = late ? random_pfn() : 40'($urandom_range(41, 1000));
					else
						item.npages = late ? PFN_MAX : 40'd1;
					if (item.npages == '0)
						item.npages = 40'd1;
				end
			end else begin
				item.op = OP_ALLOC;
			end

			sender_gap(idle_on);
			issue(item, 1'b0, '0);
		end

		// Let every owed response arrive, then watch for strays.
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d requests (%0d from the directed table), checked %0d responses.",
			xfers_taken, n_directed, results_seen);
		$display("Responses seen: %0d stack full, %0d nothing free, %0d zero-count; %0d faults.",
			n_full, n_empty, n_zero, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("Watchdog expired with %0d responses outstanding.", pending_rsp.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/pefl_pkg.sv
rtl/pefl_ram.sv
rtl/pefl_front.sv
rtl/pefl_queue.sv
rtl/pefl_back.sv
rtl/page_extent_free_list_allocator.sv
sim/tb_top.sv
